// ===== rtl/grce_pkg.sv =====
`default_nettype none
package grce_pkg;

  localparam int ROW_W = 32;
  localparam int COORD_W = 16;
  localparam int COLOR_W = 16;
  localparam int GW_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ASCENT   = 3'd4;

  typedef struct packed {
    logic [31:0]       row_bits;
    logic [5:0]        row_number;
    logic [5:0]        glyph_width;
    logic signed [7:0] box_dx;
    logic [7:0]        box_rise;
    logic [7:0]        advance;
    logic              glyph_end;
    logic              text_begin;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [15:0] color;
    logic        row_last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [15:0] start_x;
    logic [15:0] origin_y;
    logic [7:0]  ascent;
  } cfg_regs_t;

  // one row run handed from front to back; width is never zero
  typedef struct packed {
    logic [ROW_W-1:0]   row_bits;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y;
    logic [GW_W-1:0]    width;
  } run_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/grce_front.sv =====
`default_nettype none
module grce_front #(
  parameter int MAX_GLYPH_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire grce_pkg::cfg_regs_t  cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire grce_pkg::in_item_t   in_data,
  input  wire logic                 q_full,
  output logic                      q_push,
  output grce_pkg::run_cmd_t        q_cmd
);

  localparam int COL_LIMIT = (MAX_GLYPH_WIDTH < grce_pkg::ROW_W) ?
                             MAX_GLYPH_WIDTH : grce_pkg::ROW_W;
  localparam logic [grce_pkg::GW_W-1:0] COL_LIMIT_W = grce_pkg::GW_W'(COL_LIMIT);

  logic [15:0]          pen_r;
  logic [15:0]          pen_nxt;
  logic [15:0]          pen_cur;
  logic [15:0]          bx16;
  logic [grce_pkg::GW_W-1:0] width_sat;
  logic                 accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign pen_cur   = in_data.text_begin ? cfg.start_x : pen_r;
  assign bx16      = {{8{in_data.box_dx[7]}}, in_data.box_dx};
  assign width_sat = (in_data.glyph_width > COL_LIMIT_W) ? COL_LIMIT_W : in_data.glyph_width;

  always_comb begin
    q_cmd.row_bits = in_data.row_bits;
    q_cmd.x0       = pen_cur + bx16;
    q_cmd.y        = cfg.origin_y + {8'd0, cfg.ascent} - {8'd0, in_data.box_rise}
                     + {10'd0, in_data.row_number};
    q_cmd.width    = width_sat;
  end

  // drop zero-width rows: they only move the pen
  assign q_push = accept && (width_sat != '0);

  assign pen_nxt = in_data.glyph_end ? (pen_cur + {8'd0, in_data.advance}) : pen_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r <= '0;
    end else if (accept) begin
      pen_r <= pen_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/grce_queue.sv =====
`default_nettype none
module grce_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire grce_pkg::run_cmd_t  push_cmd,
  output logic                     full,
  input  wire logic                pop,
  output logic                     valid,
  output grce_pkg::run_cmd_t       head
);

  grce_pkg::run_cmd_t mem_r [grce_pkg::QDEPTH];
  logic [grce_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [grce_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [grce_pkg::QCNT_W-1:0] count_r;
  logic                        do_push;
  logic                        do_pop;

  assign full    = (count_r == grce_pkg::QCNT_W'(grce_pkg::QDEPTH));
  assign valid   = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/grce_back.sv =====
`default_nettype none
module grce_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire grce_pkg::cfg_regs_t cfg,
  input  wire logic                q_valid,
  input  wire grce_pkg::run_cmd_t  q_head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output grce_pkg::out_item_t      out_data
);

  logic                        busy_r;
  logic [grce_pkg::ROW_W-1:0]  bits_r;
  logic [15:0]                 x_r;
  logic [15:0]                 y_r;
  logic [grce_pkg::GW_W-1:0]   rem_r;
  logic                        out_valid_r;
  grce_pkg::out_item_t         out_data_r;
  logic                        adv;
  logic                        emit;
  logic                        last;

  assign adv   = !out_valid_r || out_ready;
  assign emit  = adv && busy_r;
  assign last  = (rem_r == grce_pkg::GW_W'(1));
  // load the next run in the same cycle the current one emits its last pixel
  assign q_pop = q_valid && (!busy_r || (emit && last));

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= busy_r;
      end
      if (q_pop) begin
        busy_r <= 1'b1;
      end else if (emit && last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.pixel_x  <= x_r;
      out_data_r.pixel_y  <= y_r;
      out_data_r.color    <= bits_r[grce_pkg::ROW_W-1] ? cfg.fg_color : cfg.bg_color;
      out_data_r.row_last <= last;
    end
    if (q_pop) begin
      bits_r <= q_head.row_bits;
      x_r    <= q_head.x0;
      y_r    <= q_head.y;
      rem_r  <= q_head.width;
    end else if (emit) begin
      bits_r <= {bits_r[grce_pkg::ROW_W-2:0], 1'b0};
      x_r    <= x_r + 16'd1;
      rem_r  <= rem_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/glyph_row_color_expander.sv =====
`default_nettype none
// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_ready    grce_pkg::in_item_t, one glyph row
// out_     output     out_valid/out_ready  grce_pkg::out_item_t, one pixel
// cfg_     input      cfg_we               cfg_index, cfg_data (write only)
//
// A row of width w, capped at MAX_GLYPH_WIDTH and 32, yields w pixels at one
// pixel per cycle while out_ready is high; the pixel emitter sets the rate,
// queued rows run back to back, and a zero-width row is dropped at the input
// after moving the pen. Rows are taken while the two-entry run queue has room;
// a taken row reaches the output through the queue, run and pixel registers.
// Synchronous active-low reset clears the pen, queue and output valid.
// A stalled out_ready holds the pixel register and backs up into the queue.
module glyph_row_color_expander #(
  parameter int MAX_GLYPH_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire grce_pkg::in_item_t    in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output grce_pkg::out_item_t        out_data,
  input  wire logic                  cfg_we,
  input  wire logic [grce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [grce_pkg::CFG_DATA_W-1:0] cfg_data
);

  grce_pkg::cfg_regs_t cfg_r;
  grce_pkg::run_cmd_t  push_cmd;
  grce_pkg::run_cmd_t  q_head;
  logic                q_push;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fg_color <= 16'hFFFF;
      cfg_r.bg_color <= '0;
      cfg_r.start_x  <= '0;
      cfg_r.origin_y <= '0;
      cfg_r.ascent   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        grce_pkg::REG_FG_COLOR: cfg_r.fg_color <= cfg_data;
        grce_pkg::REG_BG_COLOR: cfg_r.bg_color <= cfg_data;
        grce_pkg::REG_START_X:  cfg_r.start_x  <= cfg_data;
        grce_pkg::REG_ORIGIN_Y: cfg_r.origin_y <= cfg_data;
        grce_pkg::REG_ASCENT:   cfg_r.ascent   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  grce_front #(
    .MAX_GLYPH_WIDTH(MAX_GLYPH_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  grce_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  grce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
module tb_top;
  import grce_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int MAX_W = 32;
  localparam int COL_LIMIT = (MAX_W < ROW_W) ? MAX_W : ROW_W;
  localparam int SETTLE_CYCLES = 8;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int RANDOM_ROWS = 96;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_ASCENT + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cfg_regs_t regs_model;
  logic [COORD_W-1:0] pen_x_model;
  out_item_t expected_pixels[$];
  int mismatches = 0;
  bit tx_idle_en = 1'b0;
  bit rx_stall_en = 1'b0;
  int ready_hold_req = 0;

  glyph_row_color_expander #(.MAX_GLYPH_WIDTH(MAX_W)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  function automatic in_item_t make_row(input logic [31:0] bits, input logic [5:0] row_num,
                                        input logic [5:0] width, input logic [7:0] bx,
                                        input logic [7:0] by, input logic [7:0] adv,
                                        input logic gend, input logic tbegin);
    in_item_t r;
    r.row_bits = bits;
    r.row_number = row_num;
    r.glyph_width = width;
    r.box_dx = bx;
    r.box_rise = by;
    r.advance = adv;
    r.glyph_end = gend;
    r.text_begin = tbegin;
    return r;
  endfunction

  // pen load, pixel run, then pen advance, all in 16-bit wrap
  task automatic predict_row_pixels(input in_item_t row);
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y;
    int w;
    int c;
    out_item_t px;
    if (row.text_begin) pen_x_model = regs_model.start_x;
    w = (int'(row.glyph_width) > COL_LIMIT) ? COL_LIMIT : int'(row.glyph_width);
    x0 = pen_x_model + {{8{row.box_dx[7]}}, row.box_dx};
    y = regs_model.origin_y + {8'd0, regs_model.ascent} - {8'd0, row.box_rise}
        + {10'd0, row.row_number};
    for (c = 0; c < w; c++) begin
      px.pixel_x = x0 + c[15:0];
      px.pixel_y = y;
      px.color = row.row_bits[31 - c] ? regs_model.fg_color : regs_model.bg_color;
      px.row_last = (c == w - 1);
      expected_pixels.push_back(px);
    end
    if (row.glyph_end) pen_x_model = pen_x_model + {8'd0, row.advance};
  endtask

  task automatic send_row(input in_item_t row);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= row;
    do @(posedge clk); while (!in_ready);
    predict_row_pixels(row);
  endtask

  // drop the request and let every pending pixel drain
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FG_COLOR: regs_model.fg_color = value;
      REG_BG_COLOR: regs_model.bg_color = value;
      REG_START_X:  regs_model.start_x = value;
      REG_ORIGIN_Y: regs_model.origin_y = value;
      REG_ASCENT:   regs_model.ascent = value[7:0];
      default: ;
    endcase
  endtask

  task automatic report_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin : pixel_check
    out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual x=%h y=%h color=%h last=%b",
                 $time, out_data.pixel_x, out_data.pixel_y, out_data.color,
                 out_data.row_last);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.pixel_x !== want.pixel_x)
          report_field("pixel_x", want.pixel_x, out_data.pixel_x);
        if (out_data.pixel_y !== want.pixel_y)
          report_field("pixel_y", want.pixel_y, out_data.pixel_y);
        if (out_data.color !== want.color)
          report_field("color", want.color, out_data.color);
        if (out_data.row_last !== want.row_last)
          report_field("row_last", {15'd0, want.row_last}, {15'd0, out_data.row_last});
      end
    end
  end

  initial begin : ready_driver
    int hold;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (ready_hold_req > 0) begin
        hold = ready_hold_req;
        ready_hold_req = 0;
        out_ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end else if (rx_stall_en && $urandom_range(0, 4) == 0) begin
        hold = pick_gap();
        out_ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_default_registers();
    send_row(make_row(32'hFFFF_FFFF, 6'd0, 6'd32, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
    send_row(make_row(32'hAAAA_5555, 6'd1, 6'd32, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
    send_row(make_row(32'h0000_0000, 6'd2, 6'd1, 8'd0, 8'd0, 8'd3, 1'b1, 1'b0));
    // pen has moved by the advance of the finished glyph
    send_row(make_row(32'h8000_0000, 6'd0, 6'd5, 8'd2, 8'd0, 8'd0, 1'b1, 1'b0));
  endtask

  task automatic test_width_limits();
    wait_idle();
    write_reg(REG_START_X, 16'd100);
    // zero width still loads and advances the pen
    send_row(make_row(32'hFFFF_0000, 6'd0, 6'd0, 8'd0, 8'd0, 8'd10, 1'b1, 1'b1));
    send_row(make_row($urandom(), 6'd0, 6'd63, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
    send_row(make_row($urandom(), 6'd1, 6'd33, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
    send_row(make_row(32'h1234_5678, 6'd2, 6'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
    send_row(make_row($urandom(), 6'd3, 6'd31, 8'd0, 8'd0, 8'd7, 1'b1, 1'b0));
  endtask

  task automatic test_coordinate_wrap();
    wait_idle();
    write_reg(REG_FG_COLOR, 16'h0000);
    write_reg(REG_BG_COLOR, 16'hFFFF);
    write_reg(REG_START_X, 16'hFFF0);
    write_reg(REG_ORIGIN_Y, 16'hFFFF);
    write_reg(REG_ASCENT, 16'd255);
    send_row(make_row($urandom(), 6'd63, 6'd32, 8'h80, 8'd0, 8'd0, 1'b0, 1'b1));
    send_row(make_row($urandom(), 6'd0, 6'd32, 8'h7F, 8'd255, 8'd255, 1'b1, 1'b0));
    wait_idle();
    // glyph top above the line top: y difference wraps
    write_reg(REG_ASCENT, 16'd0);
    send_row(make_row($urandom(), 6'd5, 6'd8, 8'hFF, 8'd255, 8'd255, 1'b1, 1'b0));
    send_row(make_row($urandom(), 6'd0, 6'd4, 8'h00, 8'd1, 8'd0, 1'b0, 1'b0));
  endtask

  task automatic test_register_writes();
    int r;
    wait_idle();
    // writes to unused indexes are dropped
    write_reg(REG_UNUSED_LO, 16'h5A5A);
    write_reg(REG_UNUSED_HI, 16'hA5A5);
    send_row(make_row(32'hF0F0_F0F0, 6'd2, 6'd16, 8'd1, 8'd0, 8'd0, 1'b0, 1'b1));
    wait_idle();
    for (r = REG_FG_COLOR; r <= REG_ASCENT; r++) write_reg(r[CFG_IDX_W-1:0], 16'h0000);
    send_row(make_row(32'h0F0F_0F0F, 6'd0, 6'd12, 8'd0, 8'd0, 8'd1, 1'b1, 1'b1));
    wait_idle();
    for (r = REG_FG_COLOR; r <= REG_ASCENT; r++) write_reg(r[CFG_IDX_W-1:0], 16'hFFFF);
    send_row(make_row(32'h3C3C_C3C3, 6'd9, 6'd20, 8'hF8, 8'd200, 8'd9, 1'b1, 1'b1));
  endtask

  task automatic test_random_text();
    int sent;
    int phase;
    int r;
    int h;
    int pick;
    bit first;
    logic [5:0] w;
    logic [7:0] bx;
    logic [7:0] by;
    logic [7:0] adv;
    logic [95:0] raw;
    sent = 0;
    for (phase = 0; phase < 4; phase++) begin
      wait_idle();
      for (r = REG_FG_COLOR; r <= REG_ASCENT; r++)
        write_reg(r[CFG_IDX_W-1:0], (phase == 2) ? 16'hFFFF :
                  (phase == 3) ? 16'h0000 : 16'($urandom_range(0, 65535)));
      // first phase runs without any idling on either side
      tx_idle_en = (phase != 0);
      rx_stall_en = (phase != 0);
      first = 1'b1;
      while (sent < (phase + 1) * RANDOM_ROWS / 4) begin
        if ($urandom_range(0, 6) == 0) begin
          raw = {$urandom(), $urandom(), $urandom()};
          send_row(raw[$bits(in_item_t)-1:0]);
          sent++;
        end else begin
          h = $urandom_range(1, 5);
          pick = $urandom_range(0, 9);
          w = (pick == 0) ? 6'd32 : (pick == 1) ? 6'd0 : 6'($urandom_range(1, 12));
          bx = 8'($urandom_range(0, 16)) - 8'd8;
          by = 8'($urandom_range(0, regs_model.ascent));
          adv = 8'($urandom_range(0, 255));
          for (r = 0; r < h; r++) begin
            send_row(make_row($urandom(), r[5:0], w, bx, by, adv, r == h - 1,
                              r == 0 && (first || $urandom_range(0, 7) == 0)));
            sent++;
          end
          first = 1'b0;
        end
      end
    end
  endtask

  task automatic test_output_backpressure();
    int i;
    wait_idle();
    tx_idle_en = 1'b0;
    rx_stall_en = 1'b1;
    // hold off the sink long enough to back up the run queue
    ready_hold_req = 250;
    for (i = 0; i < 10; i++)
      send_row(make_row($urandom(), i[5:0], 6'd32, 8'd3, 8'd0, 8'd12, 1'b1, i == 0));
  endtask

  task automatic test_sender_pause();
    int i;
    tx_idle_en = 1'b1;
    rx_stall_en = 1'b1;
    for (i = 0; i < 8; i++) begin
      if (i == 4) wait_idle();
      send_row(make_row($urandom(), i[5:0], 6'($urandom_range(1, 32)), 8'($urandom()),
                        8'($urandom()), 8'($urandom()), 1'($urandom_range(0, 1)), 1'b0));
    end
  endtask

  initial begin : main_seq
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    regs_model.fg_color = 16'hFFFF;
    regs_model.bg_color = 16'h0000;
    regs_model.start_x = 16'h0000;
    regs_model.origin_y = 16'h0000;
    regs_model.ascent = 8'h00;
    pen_x_model = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_default_registers();
    test_width_limits();
    test_coordinate_wrap();
    test_register_writes();
    test_random_text();
    test_output_backpressure();
    test_sender_pause();

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("%0t: timeout with %0d pixels pending", $time, expected_pixels.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== glyph_row_color_expander.f =====
rtl/grce_pkg.sv
rtl/grce_front.sv
rtl/grce_queue.sv
rtl/grce_back.sv
rtl/glyph_row_color_expander.sv
tb/sv/tb_top.sv
